[design/sptc_pkg.sv]
`default_nettype none

package sptc_pkg;

	// Field widths.
	localparam int CNT_W   = 16;  // raw and calibration counts
	localparam int TEMP_W  = 10;  // temperature points, 1/8 degC
	localparam int HUM_W   = 8;   // humidity points, 1/2 percent rH
	localparam int IDX_W   = 3;   // configuration register index
	localparam int CFG_W   = 16;  // configuration write data
	localparam int OUT_W   = 32;  // scaled result

	// Internal widths.
	localparam int DIFF_W  = CNT_W + 1;        // count differences
	localparam int SPAN_W  = TEMP_W + 1;       // point difference, signed
	localparam int PROD_W  = 28;               // interpolation products and their sum
	localparam int DEN_W   = DIFF_W + 3;       // divisor, up to five times the span
	localparam int NUMX_W  = PROD_W + 10;      // scaled dividend, signed
	localparam int NMAG_W  = 36;               // dividend magnitude and quotient
	localparam int DMAG_W  = DEN_W - 1;        // divisor magnitude
	localparam int QS_W    = NMAG_W + 1;       // signed quotient
	localparam int SUM_W   = QS_W + 1;         // quotient plus offset

	// Scale factors as shifts: humidity x128, temperature x288 = x256 + x32.
	localparam int HUM_SHIFT  = 7;
	localparam int TEMP_SH_HI = 8;
	localparam int TEMP_SH_LO = 5;

	// 32 degF scaled by 256.
	localparam logic [SUM_W-1:0] FAHR_OFFSET = SUM_W'(8192);

	typedef enum logic {
		OP_TEMP = 1'b0,
		OP_HUM  = 1'b1
	} op_t;

	typedef enum logic [IDX_W-1:0] {
		REG_TEMP_LOW_DEGC  = 3'd0,
		REG_TEMP_HIGH_DEGC = 3'd1,
		REG_TEMP_LOW_CNT   = 3'd2,
		REG_TEMP_HIGH_CNT  = 3'd3,
		REG_HUM_LOW_RH     = 3'd4,
		REG_HUM_HIGH_RH    = 3'd5,
		REG_HUM_LOW_CNT    = 3'd6,
		REG_HUM_HIGH_CNT   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [TEMP_W-1:0]       temp_low_degc_x8;
		logic [TEMP_W-1:0]       temp_high_degc_x8;
		logic signed [CNT_W-1:0] temp_low_count;
		logic signed [CNT_W-1:0] temp_high_count;
		logic [HUM_W-1:0]        hum_low_rh_x2;
		logic [HUM_W-1:0]        hum_high_rh_x2;
		logic signed [CNT_W-1:0] hum_low_count;
		logic signed [CNT_W-1:0] hum_high_count;
	} cal_t;

	// Front end to divider.
	typedef struct packed {
		logic              v;
		logic [NMAG_W-1:0] mag_n;
		logic [DMAG_W-1:0] mag_d;
		logic              neg;
		logic              humid;
		logic              err;
	} div_in_t;

	// One divider stage.
	typedef struct packed {
		logic [DMAG_W-1:0] rem;
		logic [NMAG_W-1:0] nq;
		logic [DMAG_W-1:0] dmag;
		logic              neg;
		logic              humid;
		logic              err;
	} div_t;

	// Divider to finishing stages.
	typedef struct packed {
		logic              v;
		logic [NMAG_W-1:0] q;
		logic              neg;
		logic              humid;
		logic              err;
	} quot_t;

endpackage

`default_nettype wire

[design/sptc_front.sv]
`default_nettype none

module sptc_front import sptc_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    adv,
	input  wire logic                    in_valid,
	input  wire op_t                     operation,
	input  wire logic signed [CNT_W-1:0] raw_sample,
	input  wire cal_t                    cal,
	output div_in_t                      div_in
);

	logic [TEMP_W-1:0]       pl_c, ph_c;
	logic signed [CNT_W-1:0] cl_c, ch_c;

	logic v_s1, v_s2, v_s3, v_s4;

	logic [TEMP_W-1:0]        pl_s1;
	logic signed [SPAN_W-1:0] dp_s1;
	logic signed [DIFF_W-1:0] d_s1, r_s1;
	logic                     humid_s1;

	logic signed [SPAN_W-1:0] pl_ext;
	logic signed [PROD_W-1:0] pa_s2, pb_s2;
	logic signed [DIFF_W-1:0] d_s2;
	logic                     humid_s2;

	logic signed [PROD_W-1:0] num_s3;
	logic signed [DEN_W-1:0]  den_s3;
	logic                     humid_s3, err_s3;

	logic signed [NUMX_W-1:0] num_x, num_sc, num_abs;
	logic signed [DEN_W-1:0]  den_abs;
	logic [NMAG_W-1:0]        mag_n_s4;
	logic [DMAG_W-1:0]        mag_d_s4;
	logic                     neg_s4, humid_s4, err_s4;

	always_comb begin
		if (operation == OP_HUM) begin
			pl_c = TEMP_W'(cal.hum_low_rh_x2);
			ph_c = TEMP_W'(cal.hum_high_rh_x2);
			cl_c = cal.hum_low_count;
			ch_c = cal.hum_high_count;
		end else begin
			pl_c = cal.temp_low_degc_x8;
			ph_c = cal.temp_high_degc_x8;
			cl_c = cal.temp_low_count;
			ch_c = cal.temp_high_count;
		end
	end

	assign pl_ext = {1'b0, pl_s1};

	// Temperature multiplies by 288 and divides by 5*d; humidity by 128 and d.
	always_comb begin
		num_x = NUMX_W'(num_s3);
		if (humid_s3) begin
			num_sc = num_x <<< HUM_SHIFT;
		end else begin
			num_sc = (num_x <<< TEMP_SH_HI) + (num_x <<< TEMP_SH_LO);
		end
		num_abs = num_sc[NUMX_W-1] ? -num_sc : num_sc;
		den_abs = den_s3[DEN_W-1] ? -den_s3 : den_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pl_s1    <= pl_c;
			dp_s1    <= SPAN_W'(ph_c) - SPAN_W'(pl_c);
			d_s1     <= DIFF_W'(ch_c) - DIFF_W'(cl_c);
			r_s1     <= DIFF_W'(raw_sample) - DIFF_W'(cl_c);
			humid_s1 <= (operation == OP_HUM);

			pa_s2    <= PROD_W'(pl_ext) * PROD_W'(d_s1);
			pb_s2    <= PROD_W'(r_s1) * PROD_W'(dp_s1);
			d_s2     <= d_s1;
			humid_s2 <= humid_s1;

			num_s3   <= pa_s2 + pb_s2;
			den_s3   <= humid_s2 ? DEN_W'(d_s2)
			                     : (DEN_W'(d_s2) <<< 2) + DEN_W'(d_s2);
			humid_s3 <= humid_s2;
			err_s3   <= (d_s2 == '0);

			mag_n_s4 <= num_abs[NMAG_W-1:0];
			mag_d_s4 <= den_abs[DMAG_W-1:0];
			neg_s4   <= num_sc[NUMX_W-1] ^ den_s3[DEN_W-1];
			humid_s4 <= humid_s3;
			err_s4   <= err_s3;
		end
	end

	assign div_in.v     = v_s4;
	assign div_in.mag_n = mag_n_s4;
	assign div_in.mag_d = mag_d_s4;
	assign div_in.neg   = neg_s4;
	assign div_in.humid = humid_s4;
	assign div_in.err   = err_s4;

endmodule

`default_nettype wire

[design/sptc_div.sv]
`default_nettype none

// Unsigned restoring divider, one quotient bit per stage. The nq word holds
// the dividend bits not yet used in its upper part and shifts the quotient in
// at the bottom.
module sptc_div import sptc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    adv,
	input  wire div_in_t div_in,
	output quot_t        quot
);

	div_t              pipe_s [NMAG_W];
	logic [NMAG_W-1:0] pipe_v_s;
	div_t              seed;

	always_comb begin
		seed.rem   = '0;
		seed.nq    = div_in.mag_n;
		seed.dmag  = div_in.mag_d;
		seed.neg   = div_in.neg;
		seed.humid = div_in.humid;
		seed.err   = div_in.err;
	end

	for (genvar k = 0; k < NMAG_W; k++) begin : g_stage
		div_t          src, nxt;
		logic          src_v;
		logic [DMAG_W:0] trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign src   = seed;
			assign src_v = div_in.v;
		end else begin : g_next
			assign src   = pipe_s[k-1];
			assign src_v = pipe_v_s[k-1];
		end

		always_comb begin
			trial     = {src.rem, src.nq[NMAG_W-1]};
			ge        = (trial >= {1'b0, src.dmag});
			nxt       = src;
			nxt.rem   = ge ? DMAG_W'(trial - {1'b0, src.dmag}) : trial[DMAG_W-1:0];
			nxt.nq    = {src.nq[NMAG_W-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pipe_v_s[k] <= 1'b0;
			end else if (adv) begin
				pipe_v_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pipe_s[k] <= nxt;
			end
		end
	end

	assign quot.v     = pipe_v_s[NMAG_W-1];
	assign quot.q     = pipe_s[NMAG_W-1].nq;
	assign quot.neg   = pipe_s[NMAG_W-1].neg;
	assign quot.humid = pipe_s[NMAG_W-1].humid;
	assign quot.err   = pipe_s[NMAG_W-1].err;

endmodule

`default_nettype wire

[design/sptc_out.sv]
`default_nettype none

// Sign, offset and saturation, then an output register with a skid entry.
module sptc_out import sptc_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire quot_t          quot,
	input  wire logic           out_ready,
	output logic                adv,
	output logic                out_valid,
	output logic [OUT_W-1:0]    scaled_value,
	output logic                span_error
);

	logic [QS_W-1:0]          q_ext;
	logic signed [QS_W-1:0]   qs_s1;
	logic                     v_s1, humid_s1, err_s1;

	logic signed [SUM_W-1:0]  sum;
	logic [SUM_W-OUT_W:0]     top;
	logic [OUT_W-1:0]         sat;
	logic [OUT_W-1:0]         val_s2;
	logic                     v_s2, err_s2;

	logic                     out_v_q, skid_v_q;
	logic [OUT_W-1:0]         out_val_q, skid_val_q;
	logic                     out_err_q, skid_err_q;
	logic                     pop, incoming;

	assign q_ext = {1'b0, quot.q};

	always_comb begin
		sum = SUM_W'(qs_s1) + (humid_s1 ? '0 : FAHR_OFFSET);
		top = sum[SUM_W-1:OUT_W-1];
		if ((&top) || !(|top)) begin
			sat = sum[OUT_W-1:0];
		end else if (sum[SUM_W-1]) begin
			sat = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(OUT_W-1){1'b1}}};
		end
	end

	// The pipeline moves only while the skid entry is free.
	assign adv      = !skid_v_q;
	assign pop      = out_v_q && out_ready;
	assign incoming = adv && v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= quot.v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qs_s1    <= quot.neg ? -q_ext : q_ext;
			humid_s1 <= quot.humid;
			err_s1   <= quot.err;
			val_s2   <= err_s1 ? '0 : sat;
			err_s2   <= err_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || pop) begin
			out_v_q <= incoming;
		end else if (incoming) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_val_q <= skid_val_q;
				out_err_q <= skid_err_q;
			end
		end else if (!out_v_q || pop) begin
			out_val_q <= val_s2;
			out_err_q <= err_s2;
		end else begin
			skid_val_q <= val_s2;
			skid_err_q <= err_s2;
		end
	end

	assign out_valid    = out_v_q;
	assign scaled_value = out_val_q;
	assign span_error   = out_err_q;

endmodule

`default_nettype wire

[design/sensor_two_point_calibration.sv]
`default_nettype none

// Channel   Handshake              Payload
// input     in_valid / in_ready    operation, raw_sample
// output    out_valid / out_ready  scaled_value, span_error
// config    cfg_we                 cfg_index, cfg_data
//
// One sample enters per cycle while the skid entry is free; a result passes
// through four front-end stages (select, multiply, sum, scale), a 36-stage
// divider that settles one quotient bit per stage, and two finishing stages.
// Reset clears the calibration registers and all valid bits.
// A stalled output fills the skid entry, which freezes the whole pipeline and
// drops in_ready; nothing is lost or repeated.
module sensor_two_point_calibration import sptc_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    operation,
	input  wire logic signed [CNT_W-1:0] raw_sample,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [OUT_W-1:0]      scaled_value,
	output logic                         span_error,
	input  wire logic                    cfg_we,
	input  wire logic [IDX_W-1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]        cfg_data
);

	cal_t             cal_q;
	div_in_t          div_in;
	quot_t            quot;
	logic             adv;
	logic [OUT_W-1:0] value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_TEMP_LOW_DEGC:  cal_q.temp_low_degc_x8  <= cfg_data[TEMP_W-1:0];
				REG_TEMP_HIGH_DEGC: cal_q.temp_high_degc_x8 <= cfg_data[TEMP_W-1:0];
				REG_TEMP_LOW_CNT:   cal_q.temp_low_count    <= cfg_data[CNT_W-1:0];
				REG_TEMP_HIGH_CNT:  cal_q.temp_high_count   <= cfg_data[CNT_W-1:0];
				REG_HUM_LOW_RH:     cal_q.hum_low_rh_x2     <= cfg_data[HUM_W-1:0];
				REG_HUM_HIGH_RH:    cal_q.hum_high_rh_x2    <= cfg_data[HUM_W-1:0];
				REG_HUM_LOW_CNT:    cal_q.hum_low_count     <= cfg_data[CNT_W-1:0];
				REG_HUM_HIGH_CNT:   cal_q.hum_high_count    <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	sptc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (in_valid && in_ready),
		.operation  (op_t'(operation)),
		.raw_sample (raw_sample),
		.cal        (cal_q),
		.div_in     (div_in)
	);

	sptc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.div_in (div_in),
		.quot   (quot)
	);

	sptc_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.quot         (quot),
		.out_ready    (out_ready),
		.adv          (adv),
		.out_valid    (out_valid),
		.scaled_value (value),
		.span_error   (span_error)
	);

	assign in_ready     = adv;
	assign scaled_value = value;

	// The skid entry fills only behind a result that is held at the output.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result waiting");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("pipeline froze without an output stall");

	a_span_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && span_error |-> scaled_value == '0)
		else $error("span error with nonzero value");

endmodule

`default_nettype wire
